// ===== hw/rtl/ffcc_pkg.sv =====
// Shared types, constants and helpers for the force-free current correction block.
// Used by every module under hw/rtl; depends on nothing.
package ffcc_pkg;

	// number format and datapath widths
	localparam int FRAC_BITS = 16;
	localparam int NUM_W     = 96;   // dividend: 64-bit magnitude times 32-bit factor
	localparam int DEN_W     = 64;   // divisor: sum of three squares plus floor
	localparam int QUO_W     = 33;   // quotient bits kept before saturation
	localparam int ROOT_W    = 16;   // square root of a 32-bit quotient
	localparam int ADDR_W    = 5;

	// pipeline depth of each unit
	localparam int FRONT_STAGES = 4;
	localparam int DIV_STAGES   = QUO_W + 1;
	localparam int SQRT_STAGES  = ROOT_W;
	localparam int BACK_STAGES  = 4;
	localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + SQRT_STAGES + BACK_STAGES;

	localparam logic [16:0] ONE = 17'(1 << FRAC_BITS);

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_PASS_MODE   = 3'd0,
		REG_AXIS_SELECT = 3'd1,
		REG_TIME_STEP   = 3'd2,
		REG_INV_STEP    = 3'd3,
		REG_DENOM_FLOOR = 3'd4
	} reg_idx_t;

	// pass_mode and axis_select codes
	localparam logic [1:0] MODE_DRIFT    = 2'd0;
	localparam logic [1:0] MODE_PARALLEL = 2'd1;
	localparam logic [1:0] MODE_LIMIT    = 2'd2;
	localparam logic [1:0] AXIS_X        = 2'd0;
	localparam logic [1:0] AXIS_Y        = 2'd1;
	localparam logic [1:0] AXIS_Z        = 2'd2;

	typedef enum logic [1:0] {
		OP_DRIFT,
		OP_PARALLEL,
		OP_LIMIT,
		OP_PASS
	} op_t;

	typedef struct packed {
		logic [1:0]  pass_mode;
		logic [1:0]  axis_select;
		logic [16:0] time_step;
		logic [31:0] inv_time_step;
		logic [15:0] denom_floor;
	} cfg_t;

	// per-beat context carried alongside the arithmetic
	typedef struct packed {
		op_t                op;
		logic               sgn;    // sign of the quotient (drift, parallel)
		logic               gt;     // E^2 above B^2 (limit)
		logic signed [31:0] e_own;
		logic signed [31:0] e_pend;
		logic signed [31:0] j_own;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/ffcc_front.sv =====
// Front end: products, squared magnitudes, the wide dividend and the divisor.
// Four register stages; uses ffcc_pkg.
module ffcc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  ffcc_pkg::cfg_t      cfg,
	input  logic                valid_in,
	input  logic signed [31:0]  e_x,
	input  logic signed [31:0]  e_y,
	input  logic signed [31:0]  e_z,
	input  logic signed [31:0]  b_x,
	input  logic signed [31:0]  b_y,
	input  logic signed [31:0]  b_z,
	input  logic signed [31:0]  rho,
	input  logic signed [31:0]  e_own,
	input  logic signed [31:0]  e_pend,
	input  logic signed [31:0]  j_own,
	output logic                valid_out,
	output ffcc_pkg::side_t     side_out,
	output logic [95:0]         num,
	output logic [63:0]         den
);

	// stage 1: operation decode, eleven products
	ffcc_pkg::op_t      op;
	logic signed [31:0] ca, cb, cc, cd, ba;
	logic signed [63:0] sq_w [0:5];
	logic signed [63:0] dt_w [0:2];
	logic signed [63:0] cr_w [0:1];

	always_comb begin
		if (cfg.axis_select == 2'd3) begin
			op = ffcc_pkg::OP_PASS;
		end else begin
			unique case (cfg.pass_mode)
				ffcc_pkg::MODE_DRIFT:    op = ffcc_pkg::OP_DRIFT;
				ffcc_pkg::MODE_PARALLEL: op = ffcc_pkg::OP_PARALLEL;
				ffcc_pkg::MODE_LIMIT:    op = ffcc_pkg::OP_LIMIT;
				default:                 op = ffcc_pkg::OP_PASS;
			endcase
		end
	end

	// (E x B) on the chosen axis is ca*cb - cc*cd
	always_comb begin
		case (cfg.axis_select)
			ffcc_pkg::AXIS_X: begin
				ca = e_y; cb = b_z; cc = b_y; cd = e_z; ba = b_x;
			end
			ffcc_pkg::AXIS_Y: begin
				ca = e_z; cb = b_x; cc = e_x; cd = b_z; ba = b_y;
			end
			default: begin
				ca = e_x; cb = b_y; cc = b_x; cd = e_y; ba = b_z;
			end
		endcase
	end

	assign sq_w[0] = e_x * e_x;
	assign sq_w[1] = e_y * e_y;
	assign sq_w[2] = e_z * e_z;
	assign sq_w[3] = b_x * b_x;
	assign sq_w[4] = b_y * b_y;
	assign sq_w[5] = b_z * b_z;
	assign dt_w[0] = e_x * b_x;
	assign dt_w[1] = e_y * b_y;
	assign dt_w[2] = e_z * b_z;
	assign cr_w[0] = ca * cb;
	assign cr_w[1] = cc * cd;

	logic               valid_s1;
	logic signed [63:0] sq_s1 [0:5];
	logic signed [63:0] dt_s1 [0:2];
	logic signed [63:0] cr_s1 [0:1];
	logic signed [31:0] rho_s1, ba_s1;
	ffcc_pkg::side_t    side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1          <= sq_w;
		dt_s1          <= dt_w;
		cr_s1          <= cr_w;
		rho_s1         <= rho;
		ba_s1          <= ba;
		side_s1.op     <= op;
		side_s1.sgn    <= 1'b0;
		side_s1.gt     <= 1'b0;
		side_s1.e_own  <= e_own;
		side_s1.e_pend <= e_pend;
		side_s1.j_own  <= j_own;
	end

	// stage 2: sums, magnitudes and signs
	logic [15:0]        floor_w;
	logic [63:0]        eps_w, b2_w, e2_w, m1_w;
	logic signed [64:0] x_w;
	logic signed [65:0] dot_w;
	logic [31:0]        f2_w, rho_mag, ba_mag;
	logic               sgn_w;
	ffcc_pkg::side_t    side2_w;

	assign floor_w = (cfg.denom_floor == 16'd0) ? 16'd1 : cfg.denom_floor;
	assign eps_w   = 64'(floor_w) << ffcc_pkg::FRAC_BITS;
	assign b2_w    = $unsigned(sq_s1[3]) + $unsigned(sq_s1[4]) + $unsigned(sq_s1[5]) + eps_w;
	assign e2_w    = $unsigned(sq_s1[0]) + $unsigned(sq_s1[1]) + $unsigned(sq_s1[2]) + eps_w;
	assign x_w     = 65'(cr_s1[0]) - 65'(cr_s1[1]);
	assign dot_w   = 66'(dt_s1[0]) + 66'(dt_s1[1]) + 66'(dt_s1[2]);
	assign rho_mag = rho_s1[31] ? 32'(-rho_s1) : 32'(rho_s1);
	assign ba_mag  = ba_s1[31] ? 32'(-ba_s1) : 32'(ba_s1);

	always_comb begin
		if (side_s1.op == ffcc_pkg::OP_DRIFT) begin
			m1_w  = 64'(x_w[64] ? -x_w : x_w);
			f2_w  = rho_mag;
			sgn_w = rho_s1[31] != x_w[64];
		end else begin
			m1_w  = 64'(dot_w[65] ? -dot_w : dot_w);
			f2_w  = ba_mag;
			sgn_w = dot_w[65] != ba_s1[31];
		end
	end

	// context with the quotient sign filled in
	always_comb begin
		side2_w     = side_s1;
		side2_w.sgn = sgn_w;
	end

	logic            valid_s2;
	logic [63:0]     m1_s2, b2_s2, e2_s2;
	logic [31:0]     f2_s2;
	ffcc_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		m1_s2   <= m1_w;
		f2_s2   <= f2_w;
		b2_s2   <= b2_w;
		e2_s2   <= e2_w;
		side_s2 <= side2_w;
	end

	// stage 3: 64 x 32 product as two 32 x 32 partials, E^2 against B^2
	logic            valid_s3;
	logic [63:0]     plo_s3, phi_s3, b2_s3, e2_s3;
	ffcc_pkg::side_t side_s3;
	ffcc_pkg::side_t side3_w;

	always_comb begin
		side3_w    = side_s2;
		side3_w.gt = e2_s2 > b2_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		plo_s3  <= 64'(m1_s2[31:0]) * 64'(f2_s2);
		phi_s3  <= 64'(m1_s2[63:32]) * 64'(f2_s2);
		b2_s3   <= b2_s2;
		e2_s3   <= e2_s2;
		side_s3 <= side3_w;
	end

	// stage 4: dividend and divisor
	logic            valid_s4;
	logic [95:0]     num_s4;
	logic [63:0]     den_s4;
	ffcc_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		if (side_s3.op == ffcc_pkg::OP_LIMIT) begin
			num_s4 <= 96'(b2_s3) << (2 * ffcc_pkg::FRAC_BITS);
			den_s4 <= e2_s3;
		end else begin
			num_s4 <= (96'(phi_s3) << 32) + 96'(plo_s3);
			den_s4 <= b2_s3;
		end
	end

	assign valid_out = valid_s4;
	assign side_out  = side_s4;
	assign num       = num_s4;
	assign den       = den_s4;

endmodule

// ===== hw/rtl/ffcc_div.sv =====
// Pipelined restoring divider: an overflow check, then one quotient bit per stage.
// Keeps 33 quotient bits and flags larger quotients; uses ffcc_pkg.
module ffcc_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  ffcc_pkg::side_t side_in,
	input  logic [95:0]     num,
	input  logic [63:0]     den,
	output logic            valid_out,
	output ffcc_pkg::side_t side_out,
	output logic [32:0]     quo,
	output logic            ovf
);

	localparam int STEPS = ffcc_pkg::QUO_W;

	// overflow stage: quotient would need more than QUO_W bits
	logic            valid0_s;
	logic [95:0]     rem0_s;
	logic [63:0]     den0_s;
	logic            ovf0_s;
	ffcc_pkg::side_t side0_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_s <= 1'b0;
		end else begin
			valid0_s <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		rem0_s  <= num;
		den0_s  <= den;
		ovf0_s  <= 97'(num) >= (97'(den) << STEPS);
		side0_s <= side_in;
	end

	logic            valid_s [0:STEPS-1];
	logic [95:0]     rem_s   [0:STEPS-1];
	logic [63:0]     den_s   [0:STEPS-1];
	logic [32:0]     quo_s   [0:STEPS-1];
	logic            ovf_s   [0:STEPS-1];
	ffcc_pkg::side_t side_s  [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int SH = STEPS - 1 - k;
		logic            valid_i, ovf_i, take;
		logic [95:0]     rem_i;
		logic [63:0]     den_i;
		logic [32:0]     quo_i;
		logic [96:0]     diff;
		ffcc_pkg::side_t side_i;

		if (k == 0) begin : g_first
			assign valid_i = valid0_s;
			assign rem_i   = rem0_s;
			assign den_i   = den0_s;
			assign quo_i   = '0;
			assign ovf_i   = ovf0_s;
			assign side_i  = side0_s;
		end else begin : g_next
			assign valid_i = valid_s[k-1];
			assign rem_i   = rem_s[k-1];
			assign den_i   = den_s[k-1];
			assign quo_i   = quo_s[k-1];
			assign ovf_i   = ovf_s[k-1];
			assign side_i  = side_s[k-1];
		end

		// trial subtract of the divisor at this bit weight
		assign diff = {1'b0, rem_i} - (97'(den_i) << SH);
		assign take = !diff[96];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? diff[95:0] : rem_i;
			den_s[k]  <= den_i;
			quo_s[k]  <= {quo_i[31:0], take};
			ovf_s[k]  <= ovf_i;
			side_s[k] <= side_i;
		end
	end

	assign valid_out = valid_s[STEPS-1];
	assign side_out  = side_s[STEPS-1];
	assign quo       = quo_s[STEPS-1];
	assign ovf       = ovf_s[STEPS-1];

endmodule

// ===== hw/rtl/ffcc_sqrt.sv =====
// Pipelined integer square root of the low 32 quotient bits, one result bit per stage.
// Carries the quotient and its overflow flag alongside; uses ffcc_pkg.
module ffcc_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  ffcc_pkg::side_t side_in,
	input  logic [32:0]     quo_in,
	input  logic            ovf_in,
	output logic            valid_out,
	output ffcc_pkg::side_t side_out,
	output logic [15:0]     root,
	output logic [32:0]     quo_out,
	output logic            ovf_out
);

	localparam int STEPS = ffcc_pkg::ROOT_W;

	logic            valid_s [0:STEPS-1];
	logic [31:0]     v_s     [0:STEPS-1];
	logic [31:0]     res_s   [0:STEPS-1];
	logic [32:0]     quo_s   [0:STEPS-1];
	logic            ovf_s   [0:STEPS-1];
	ffcc_pkg::side_t side_s  [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [31:0] BIT = 32'(1) << (2 * (STEPS - 1 - k));
		logic            valid_i, ovf_i, fits;
		logic [31:0]     v_i, res_i;
		logic [32:0]     quo_i, trial;
		ffcc_pkg::side_t side_i;

		if (k == 0) begin : g_first
			assign valid_i = valid_in;
			assign v_i     = quo_in[31:0];
			assign res_i   = '0;
			assign quo_i   = quo_in;
			assign ovf_i   = ovf_in;
			assign side_i  = side_in;
		end else begin : g_next
			assign valid_i = valid_s[k-1];
			assign v_i     = v_s[k-1];
			assign res_i   = res_s[k-1];
			assign quo_i   = quo_s[k-1];
			assign ovf_i   = ovf_s[k-1];
			assign side_i  = side_s[k-1];
		end

		assign trial = 33'(res_i) + 33'(BIT);
		assign fits  = 33'(v_i) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_i;
			end
		end

		always_ff @(posedge clk) begin
			v_s[k]    <= fits ? v_i - trial[31:0] : v_i;
			res_s[k]  <= fits ? (res_i >> 1) + BIT : res_i >> 1;
			quo_s[k]  <= quo_i;
			ovf_s[k]  <= ovf_i;
			side_s[k] <= side_i;
		end
	end

	assign valid_out = valid_s[STEPS-1];
	assign side_out  = side_s[STEPS-1];
	assign root      = res_s[STEPS-1][15:0];
	assign quo_out   = quo_s[STEPS-1];
	assign ovf_out   = ovf_s[STEPS-1];

endmodule

// ===== hw/rtl/ffcc_back.sv =====
// Back end: quotient clamping, the time-step products and the saturated results.
// Four register stages, the last drives the result ports; uses ffcc_pkg.
module ffcc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ffcc_pkg::cfg_t     cfg,
	input  logic               valid_in,
	input  ffcc_pkg::side_t    side_in,
	input  logic [15:0]        root,
	input  logic [32:0]        quo,
	input  logic               ovf,
	output logic               done,
	output logic signed [31:0] current_new,
	output logic signed [31:0] e_new
);

	localparam logic [32:0] CAP_NEG = 33'h0_8000_0000;
	localparam logic [32:0] CAP_POS = 33'h0_7FFF_FFFF;
	localparam logic [32:0] CAP_PAR = 33'h1_0000_0000;

	// stage 1: clamp the quotient, pick the multiplier operands
	logic [16:0] d_w;
	logic [31:0] ep_mag;
	logic [32:0] ma_w, cap;
	logic [31:0] mb_w;
	logic        neg_w;

	assign d_w    = side_in.gt ? 17'(root) : ffcc_pkg::ONE;
	assign ep_mag = side_in.e_pend[31] ? 32'(-side_in.e_pend) : 32'(side_in.e_pend);

	always_comb begin
		cap   = CAP_PAR;
		ma_w  = '0;
		mb_w  = '0;
		neg_w = 1'b0;
		case (side_in.op)
			ffcc_pkg::OP_DRIFT: begin
				cap   = side_in.sgn ? CAP_NEG : CAP_POS;
				ma_w  = (ovf || quo > cap) ? cap : quo;
				mb_w  = 32'(cfg.time_step);
				neg_w = side_in.sgn && (ma_w != '0);
			end
			ffcc_pkg::OP_PARALLEL: begin
				ma_w  = (ovf || quo > CAP_PAR) ? CAP_PAR : quo;
				mb_w  = cfg.inv_time_step;
				neg_w = side_in.sgn;
			end
			ffcc_pkg::OP_LIMIT: begin
				ma_w  = 33'(ep_mag);
				mb_w  = 32'(ffcc_pkg::ONE - d_w);
				neg_w = side_in.e_pend[31];
			end
			default: begin
				ma_w  = '0;
			end
		endcase
	end

	logic            valid_s1, neg_s1;
	logic [32:0]     ma_s1;
	logic [31:0]     mb_s1;
	logic [16:0]     d_s1;
	ffcc_pkg::side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1   <= ma_w;
		mb_s1   <= mb_w;
		d_s1    <= d_w;
		neg_s1  <= neg_w;
		side_s1 <= side_in;
	end

	// stage 2: main product and the limited-E product
	logic            valid_s2, neg_s2;
	logic [32:0]     ma_s2;
	logic [64:0]     pa_s2;
	logic [48:0]     pb_s2;
	ffcc_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pa_s2   <= 65'(ma_s1) * 65'(mb_s1);
		pb_s2   <= 49'(d_s1) * 49'(ma_s1[31:0]);
		ma_s2   <= ma_s1;
		neg_s2  <= neg_s1;
		side_s2 <= side_s1;
	end

	// stage 3: dissipated E times 1/dt as two 24 x 32 partials
	logic            valid_s3, neg_s3;
	logic [32:0]     ma_s3;
	logic [64:0]     pa_s3;
	logic [48:0]     pb_s3;
	logic [55:0]     plo_s3, phi_s3;
	ffcc_pkg::side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		plo_s3  <= 56'(pa_s2[23:0]) * 56'(cfg.inv_time_step);
		phi_s3  <= 56'(pa_s2[47:24]) * 56'(cfg.inv_time_step);
		pa_s3   <= pa_s2;
		pb_s3   <= pb_s2;
		ma_s3   <= ma_s2;
		neg_s3  <= neg_s2;
		side_s3 <= side_s2;
	end

	// stage 4: signed sums and saturation
	logic [79:0]        lim_sum;
	logic signed [67:0] ma_v, pa_v, pb_v, lim_v, j_w, e_w;

	assign lim_sum = (80'(phi_s3) << 24) + 80'(plo_s3);
	assign ma_v    = $signed(68'(ma_s3));
	assign pa_v    = $signed(68'(pa_s3 >> ffcc_pkg::FRAC_BITS));
	assign pb_v    = $signed(68'(pb_s3 >> ffcc_pkg::FRAC_BITS));
	assign lim_v   = $signed(68'(lim_sum[79:32]));

	always_comb begin
		case (side_s3.op)
			ffcc_pkg::OP_DRIFT: begin
				j_w = neg_s3 ? -ma_v : ma_v;
				e_w = 68'(side_s3.e_pend) - (neg_s3 ? -pa_v : pa_v);
			end
			ffcc_pkg::OP_PARALLEL: begin
				j_w = 68'(side_s3.j_own) + (neg_s3 ? -pa_v : pa_v);
				e_w = 68'(side_s3.e_own) - (neg_s3 ? -ma_v : ma_v);
			end
			ffcc_pkg::OP_LIMIT: begin
				j_w = 68'(side_s3.j_own) + (neg_s3 ? -lim_v : lim_v);
				e_w = neg_s3 ? -pb_v : pb_v;
			end
			default: begin
				j_w = 68'(side_s3.j_own);
				e_w = 68'(side_s3.e_pend);
			end
		endcase
	end

	logic               valid_s4;
	logic signed [31:0] j_s4, e_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		j_s4 <= ffcc_pkg::sat32(j_w);
		e_s4 <= ffcc_pkg::sat32(e_w);
	end

	assign done        = valid_s4;
	assign current_new = j_s4;
	assign e_new       = e_s4;

endmodule

// ===== hw/rtl/force_free_current_correction.sv =====
// Force-free electrodynamics current correction, one staggered grid point per beat.
// Top level: configuration registers, front end, divider, square root, back end.
//
// Use: drive the ten input fields and raise start; a beat is taken at every
// clock edge with start high and busy low. busy stays low, so a new beat may
// enter every cycle and one result leaves every cycle at full load.
// The pipeline has 4 front-end stages (products, sums, dividend), 34 divider
// stages (overflow check and one quotient bit a stage), 16 square root stages
// (one root bit a stage) and 4 back-end stages. The divider's quotient bit
// chain is the deepest of these units.
// Each result is shown on current_new and e_new for one cycle with done high;
// the receiver cannot hold results off, so nothing ever stalls.
// Configuration goes through the APB-style port (pready always high, register
// i at byte address 4*i); the user must write it only while no beat is in
// flight; the block itself does not enforce this. Reset clears every valid bit,
// so no done follows reset until a new beat has gone through, and loads the
// register defaults: drift mode, x axis, dt = 1.0, 1/dt = 1.0, floor = 1.
module force_free_current_correction (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] e_x_at_point,
	input  logic signed [31:0] e_y_at_point,
	input  logic signed [31:0] e_z_at_point,
	input  logic signed [31:0] b_x_at_point,
	input  logic signed [31:0] b_y_at_point,
	input  logic signed [31:0] b_z_at_point,
	input  logic signed [31:0] charge_density,
	input  logic signed [31:0] e_own,
	input  logic signed [31:0] e_pending,
	input  logic signed [31:0] current_own,
	output logic               done,
	output logic signed [31:0] current_new,
	output logic signed [31:0] e_new
);

	// configuration registers
	logic [1:0]  pass_mode_q, axis_select_q;
	logic [16:0] time_step_q;
	logic [31:0] inv_step_q;
	logic [15:0] floor_q;
	logic        wr_en;
	ffcc_pkg::reg_idx_t reg_idx;
	ffcc_pkg::cfg_t     cfg;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = ffcc_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_mode_q   <= ffcc_pkg::MODE_DRIFT;
			axis_select_q <= ffcc_pkg::AXIS_X;
			time_step_q   <= ffcc_pkg::ONE;
			inv_step_q    <= 32'(ffcc_pkg::ONE);
			floor_q       <= 16'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				ffcc_pkg::REG_PASS_MODE:   pass_mode_q   <= pwdata[1:0];
				ffcc_pkg::REG_AXIS_SELECT: axis_select_q <= pwdata[1:0];
				ffcc_pkg::REG_TIME_STEP:   time_step_q   <= pwdata[16:0];
				ffcc_pkg::REG_INV_STEP:    inv_step_q    <= pwdata;
				ffcc_pkg::REG_DENOM_FLOOR: floor_q       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			ffcc_pkg::REG_PASS_MODE:   prdata = 32'(pass_mode_q);
			ffcc_pkg::REG_AXIS_SELECT: prdata = 32'(axis_select_q);
			ffcc_pkg::REG_TIME_STEP:   prdata = 32'(time_step_q);
			ffcc_pkg::REG_INV_STEP:    prdata = inv_step_q;
			ffcc_pkg::REG_DENOM_FLOOR: prdata = 32'(floor_q);
			default:                   prdata = '0;
		endcase
	end

	assign cfg.pass_mode     = pass_mode_q;
	assign cfg.axis_select   = axis_select_q;
	assign cfg.time_step     = time_step_q;
	assign cfg.inv_time_step = inv_step_q;
	assign cfg.denom_floor   = floor_q;

	// datapath
	logic            fe_valid, div_valid, sq_valid;
	ffcc_pkg::side_t fe_side, div_side, sq_side;
	logic [95:0]     fe_num;
	logic [63:0]     fe_den;
	logic [32:0]     div_quo, sq_quo;
	logic            div_ovf, sq_ovf;
	logic [15:0]     sq_root;

	ffcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_in  (start && !busy),
		.e_x       (e_x_at_point),
		.e_y       (e_y_at_point),
		.e_z       (e_z_at_point),
		.b_x       (b_x_at_point),
		.b_y       (b_y_at_point),
		.b_z       (b_z_at_point),
		.rho       (charge_density),
		.e_own     (e_own),
		.e_pend    (e_pending),
		.j_own     (current_own),
		.valid_out (fe_valid),
		.side_out  (fe_side),
		.num       (fe_num),
		.den       (fe_den)
	);

	ffcc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (fe_valid),
		.side_in   (fe_side),
		.num       (fe_num),
		.den       (fe_den),
		.valid_out (div_valid),
		.side_out  (div_side),
		.quo       (div_quo),
		.ovf       (div_ovf)
	);

	ffcc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (div_valid),
		.side_in   (div_side),
		.quo_in    (div_quo),
		.ovf_in    (div_ovf),
		.valid_out (sq_valid),
		.side_out  (sq_side),
		.root      (sq_root),
		.quo_out   (sq_quo),
		.ovf_out   (sq_ovf)
	);

	ffcc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.valid_in    (sq_valid),
		.side_in     (sq_side),
		.root        (sq_root),
		.quo         (sq_quo),
		.ovf         (sq_ovf),
		.done        (done),
		.current_new (current_new),
		.e_new       (e_new)
	);

	// a result only ever follows an accepted beat by the full latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ffcc_pkg::LATENCY))
		else $error("result without a matching beat");

	// with E^2 above B^2 the limiting ratio is below one, so no overflow
	a_limit_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid && div_side.op == ffcc_pkg::OP_LIMIT && div_side.gt)
		|-> (!div_ovf && !div_quo[32]))
		else $error("limit quotient out of range");

	// the square root pipeline invents no beats
	a_sqrt_flow: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid |-> $past(div_valid, ffcc_pkg::SQRT_STAGES))
		else $error("square root stage out of step");

endmodule
